[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the compass axis calibrator. Define
// NO_ASSERTIONS to compile every use to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)

`define CAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/cac_pkg.sv]
// ----------------------------------------------------------------------------
// cac_pkg
// Types, constants and codes shared by the compass axis calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

    localparam int AXES          = 3;
    localparam int BYTE_W        = 8;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int OUT_W         = 24;
    localparam int FRAC_BITS_DEF = 12;
    localparam int RAW_WIDTH_DEF = 16;

    localparam logic signed [CFG_W-1:0] ERR_CODE      = CFG_W'(-4096);
    localparam logic signed [CFG_W-1:0] LIMIT_MIN_RST = CFG_W'(-400);
    localparam logic signed [CFG_W-1:0] LIMIT_MAX_RST = CFG_W'(400);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_CAL,
        CFG_MIN_X,
        CFG_MIN_Y,
        CFG_MIN_Z,
        CFG_MAX_X,
        CFG_MAX_Y,
        CFG_MAX_Z
    } t_cfg_idx;

    typedef enum logic {
        T_IDLE,
        T_BUSY
    } t_top_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PREP,
        L_ABS,
        L_CHECK,
        L_DIV,
        L_FIN,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic err;
        logic reload;
        logic track;
        logic cal;
    } t_lane_cmd;

    typedef struct packed {
        logic             done;
        logic             clip;
        logic [OUT_W-1:0] field;
    } t_lane_res;

endpackage

`default_nettype wire

[hdl/cac_in_if.sv]
// ----------------------------------------------------------------------------
// cac_in_if
// Input channel: the six data bytes of one sensor read and a reload flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_in_if;

    logic                        valid;
    logic                        ready;
    logic                        reload_limits;
    logic [cac_pkg::BYTE_W-1:0]  x_high_byte;
    logic [cac_pkg::BYTE_W-1:0]  x_low_byte;
    logic [cac_pkg::BYTE_W-1:0]  z_high_byte;
    logic [cac_pkg::BYTE_W-1:0]  z_low_byte;
    logic [cac_pkg::BYTE_W-1:0]  y_high_byte;
    logic [cac_pkg::BYTE_W-1:0]  y_low_byte;

    modport source (
        output valid, reload_limits, x_high_byte, x_low_byte,
               z_high_byte, z_low_byte, y_high_byte, y_low_byte,
        input  ready
    );

    modport sink (
        input  valid, reload_limits, x_high_byte, x_low_byte,
               z_high_byte, z_low_byte, y_high_byte, y_low_byte,
        output ready
    );

endinterface

`default_nettype wire

[hdl/cac_out_if.sv]
// ----------------------------------------------------------------------------
// cac_out_if
// Output channel: normalized field per axis and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [cac_pkg::OUT_W-1:0]  field_x;
    logic signed [cac_pkg::OUT_W-1:0]  field_y;
    logic signed [cac_pkg::OUT_W-1:0]  field_z;
    logic                              measure_error;
    logic                              clipped;

    modport source (
        output valid, field_x, field_y, field_z, measure_error, clipped,
        input  ready
    );

    modport sink (
        input  valid, field_x, field_y, field_z, measure_error, clipped,
        output ready
    );

endinterface

`default_nettype wire

[hdl/cac_lane.sv]
// ----------------------------------------------------------------------------
// cac_lane
// One axis: raw and limit tracking, then a restoring divider for the rounded,
// saturated quotient (2*raw-max-min)/(max-min); until calibrated, scaled raw.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_lane #(
    parameter int FRAC_BITS = cac_pkg::FRAC_BITS_DEF,
    parameter int RAW_WIDTH = cac_pkg::RAW_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cac_pkg::t_lane_cmd                i_cmd,
    input  wire logic signed [RAW_WIDTH-1:0]       i_raw,
    input  wire logic signed [cac_pkg::CFG_W-1:0]  i_preset_min,
    input  wire logic signed [cac_pkg::CFG_W-1:0]  i_preset_max,
    input  wire logic                              i_take,
    output cac_pkg::t_lane_res                     o_res
);

    localparam int CW     = cac_pkg::CFG_W;
    localparam int OW     = cac_pkg::OUT_W;
    localparam int NB_W   = CW + 2;
    localparam int DIF_W  = CW + 1;
    localparam int NUM_W  = NB_W + FRAC_BITS;
    localparam int DVD_W  = NUM_W + 1;
    localparam int DEN_W  = CW + 1;
    localparam int CMP_W  = (DVD_W > DEN_W + OW) ? DVD_W : DEN_W + OW;
    localparam int SC_W   = (RAW_WIDTH + FRAC_BITS > OW) ? RAW_WIDTH + FRAC_BITS : OW;
    localparam int CNT_W  = $clog2(OW);

    localparam logic [OW-1:0] NEG_LIM = {1'b1, {(OW-1){1'b0}}};

    cac_pkg::t_lane_state r_state, n_state;

    logic signed [RAW_WIDTH-1:0] r_raw, n_raw;
    logic signed [CW-1:0]        r_min, n_min;
    logic signed [CW-1:0]        r_max, n_max;
    logic                        r_cal, n_cal;
    logic signed [NB_W-1:0]      r_nb, n_nb;
    logic signed [DIF_W-1:0]     r_den, n_den;
    logic [CMP_W-1:0]            r_rem, n_rem;
    logic [CMP_W-1:0]            r_dvs, n_dvs;
    logic [OW-1:0]               r_quo, n_quo;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;
    logic [OW-1:0]               r_field, n_field;
    logic                        r_clip, n_clip;

    logic signed [RAW_WIDTH-1:0] cur;
    logic signed [CW-1:0]        cur_ext;
    logic signed [CW-1:0]        lo0;
    logic signed [CW-1:0]        hi0;
    logic signed [CW-1:0]        lo_t;
    logic signed [CW-1:0]        hi_t;
    logic signed [NB_W-1:0]      nb;
    logic signed [DIF_W-1:0]     den;
    logic signed [NUM_W-1:0]     num;
    logic [NUM_W-1:0]            an;
    logic [DIF_W-1:0]            ad;
    logic [DVD_W-1:0]            dvd;
    logic [DEN_W-1:0]            dvs;
    logic                        ge;
    logic                        neg;
    logic signed [SC_W-1:0]      wide;
    logic [OW-1:0]               fin_field;
    logic                        fin_clip;

    assign cur     = i_cmd.err ? r_raw : i_raw;
    assign cur_ext = CW'(cur);
    assign lo0     = i_cmd.reload ? i_preset_min : r_min;
    assign hi0     = i_cmd.reload ? i_preset_max : r_max;
    assign lo_t    = (i_cmd.track && (cur_ext < lo0)) ? cur_ext : lo0;
    assign hi_t    = (i_cmd.track && (cur_ext > hi0)) ? cur_ext : hi0;

    assign nb  = (NB_W'(r_raw) <<< 1) - NB_W'(r_max) - NB_W'(r_min);
    assign den = DIF_W'(r_max) - DIF_W'(r_min);

    assign num = NUM_W'(r_nb) <<< FRAC_BITS;
    assign an  = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
    assign ad  = r_den[DIF_W-1] ? $unsigned(-r_den) : $unsigned(r_den);
    assign dvd = {an, 1'b0} + DVD_W'(ad);
    assign dvs = {ad[CW-1:0], 1'b0};

    assign ge   = (r_rem >= r_dvs);
    assign neg  = r_nb[NB_W-1] ^ r_den[DIF_W-1];
    assign wide = SC_W'(r_raw) <<< FRAC_BITS;

    always_comb begin
        fin_field = r_quo;
        fin_clip  = 1'b0;
        priority if (!r_cal) begin
            if (wide > SC_W'(cac_pkg::OUT_MAX)) begin
                fin_field = cac_pkg::OUT_MAX;
                fin_clip  = 1'b1;
            end else if (wide < SC_W'(cac_pkg::OUT_MIN)) begin
                fin_field = cac_pkg::OUT_MIN;
                fin_clip  = 1'b1;
            end else begin
                fin_field = wide[OW-1:0];
            end
        end else if (r_den == '0) begin
            fin_clip = 1'b1;
            if (r_nb > 0) begin
                fin_field = cac_pkg::OUT_MAX;
            end else if (r_nb < 0) begin
                fin_field = cac_pkg::OUT_MIN;
            end else begin
                fin_field = '0;
            end
        end else if (!neg) begin
            if (r_ovf || r_quo[OW-1]) begin
                fin_field = cac_pkg::OUT_MAX;
                fin_clip  = 1'b1;
            end
        end else begin
            if (r_ovf || (r_quo > NEG_LIM)) begin
                fin_field = cac_pkg::OUT_MIN;
                fin_clip  = 1'b1;
            end else begin
                fin_field = OW'(0) - r_quo;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cac_pkg::L_IDLE: begin
                if (i_cmd.start) begin
                    n_state = cac_pkg::L_PREP;
                end
            end
            cac_pkg::L_PREP:  n_state = cac_pkg::L_ABS;
            cac_pkg::L_ABS:   n_state = cac_pkg::L_CHECK;
            cac_pkg::L_CHECK: n_state = cac_pkg::L_DIV;
            cac_pkg::L_DIV: begin
                if (r_cnt == CNT_W'(OW - 1)) begin
                    n_state = cac_pkg::L_FIN;
                end
            end
            cac_pkg::L_FIN:   n_state = cac_pkg::L_DONE;
            cac_pkg::L_DONE: begin
                if (i_take) begin
                    n_state = cac_pkg::L_IDLE;
                end
            end
            default:          n_state = cac_pkg::L_IDLE;
        endcase
    end

    always_comb begin
        o_res.done  = (r_state == cac_pkg::L_DONE);
        o_res.clip  = r_clip;
        o_res.field = r_field;
    end

    always_comb begin
        n_raw   = r_raw;
        n_min   = r_min;
        n_max   = r_max;
        n_cal   = r_cal;
        n_nb    = r_nb;
        n_den   = r_den;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_field = r_field;
        n_clip  = r_clip;
        unique case (r_state)
            cac_pkg::L_IDLE: begin
                if (i_cmd.start) begin
                    n_raw = cur;
                    n_min = lo_t;
                    n_max = hi_t;
                    n_cal = i_cmd.cal;
                end
            end
            cac_pkg::L_PREP: begin
                n_nb  = nb;
                n_den = den;
            end
            cac_pkg::L_ABS: begin
                n_rem = CMP_W'(dvd);
                n_dvs = CMP_W'(dvs) << OW;
            end
            cac_pkg::L_CHECK: begin
                n_ovf = ge;
                n_dvs = r_dvs >> 1;
                n_cnt = '0;
                n_quo = '0;
            end
            cac_pkg::L_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dvs;
                end
                n_quo = {r_quo[OW-2:0], ge};
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt + CNT_W'(1);
            end
            cac_pkg::L_FIN: begin
                n_field = fin_field;
                n_clip  = fin_clip;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cac_pkg::L_IDLE;
            r_raw   <= '0;
            r_min   <= cac_pkg::LIMIT_MIN_RST;
            r_max   <= cac_pkg::LIMIT_MAX_RST;
        end else begin
            r_state <= n_state;
            r_raw   <= n_raw;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cal   <= n_cal;
        r_nb    <= n_nb;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_ovf   <= n_ovf;
        r_field <= n_field;
        r_clip  <= n_clip;
    end

endmodule

`default_nettype wire

[hdl/cac_merge.sv]
// ----------------------------------------------------------------------------
// cac_merge
// Collects the three lane results into the output register and releases
// the lanes once the item has been captured.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_merge (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cac_pkg::t_lane_res  i_res [cac_pkg::AXES],
    input  wire logic                i_err,
    output logic                     o_take,
    cac_out_if.source                o_result
);

    logic                        r_valid;
    logic [cac_pkg::OUT_W-1:0]   r_field [cac_pkg::AXES];
    logic                        r_err;
    logic                        r_clip;
    logic                        all_done;
    logic                        any_clip;

    assign all_done = i_res[0].done && i_res[1].done && i_res[2].done;
    assign any_clip = i_res[0].clip || i_res[1].clip || i_res[2].clip;
    assign o_take   = all_done && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_field[0] <= i_res[0].field;
            r_field[1] <= i_res[1].field;
            r_field[2] <= i_res[2].field;
            r_err      <= i_err;
            r_clip     <= any_clip;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.field_x       = r_field[0];
    assign o_result.field_y       = r_field[1];
    assign o_result.field_z       = r_field[2];
    assign o_result.measure_error = r_err;
    assign o_result.clipped       = r_clip;

endmodule

`default_nettype wire

[hdl/compass_axis_calibrator_top.sv]
// ----------------------------------------------------------------------------
// compass_axis_calibrator_top
// Magnetometer hard-iron calibrator: tracks per-axis limits and scales each
// axis to a signed fixed-point field in three parallel divider lanes.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake        Content
//   i_item     in         valid / ready    reload flag and six sensor bytes
//   o_result   out        valid / ready    three fields, error, clipped
//   i_cfg_*    in         write enable     register index and value
//
// One item occupies the lanes from acceptance until the merge takes its
// result, and no new item is accepted before then; each lane's 24-step
// restoring divider runs between its check and finish states.
// Reset is synchronous and active low; it restores presets and tracked
// limits, clears the raw history and the calibrated flag.
// A stalled output holds its result while the next item is already accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module compass_axis_calibrator_top #(
    parameter int FRAC_BITS = cac_pkg::FRAC_BITS_DEF,
    parameter int RAW_WIDTH = cac_pkg::RAW_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cac_pkg::CFG_W-1:0]         i_cfg_data,
    cac_in_if.sink                                 i_item,
    cac_out_if.source                              o_result
);

    localparam int CW = cac_pkg::CFG_W;

    cac_pkg::t_top_state          r_state, n_state;
    logic                         r_auto;
    logic signed [CW-1:0]         r_pmin [cac_pkg::AXES];
    logic signed [CW-1:0]         r_pmax [cac_pkg::AXES];
    logic                         r_cal, n_cal;
    logic                         r_err;

    logic [CW-1:0]                word [cac_pkg::AXES];
    logic signed [RAW_WIDTH-1:0]  raw [cac_pkg::AXES];
    logic                         err;
    logic                         accept;
    logic                         track;
    logic                         in_ready;
    cac_pkg::t_lane_cmd           lane_cmd;
    cac_pkg::t_lane_res           lane_res [cac_pkg::AXES];
    logic [cac_pkg::AXES-1:0]     lane_done;
    logic                         lane_take;

    assign word[0] = {i_item.x_high_byte, i_item.x_low_byte};
    assign word[1] = {i_item.y_high_byte, i_item.y_low_byte};
    assign word[2] = {i_item.z_high_byte, i_item.z_low_byte};

    assign raw[0] = word[0][RAW_WIDTH-1:0];
    assign raw[1] = word[1][RAW_WIDTH-1:0];
    assign raw[2] = word[2][RAW_WIDTH-1:0];

    assign err = (CW'(raw[0]) == cac_pkg::ERR_CODE)
              || (CW'(raw[1]) == cac_pkg::ERR_CODE)
              || (CW'(raw[2]) == cac_pkg::ERR_CODE);

    assign accept = i_item.valid && in_ready;
    assign track  = i_item.reload_limits || r_auto;
    assign n_cal  = accept ? (r_cal || track) : r_cal;

    always_comb begin
        lane_cmd.start  = accept;
        lane_cmd.err    = err;
        lane_cmd.reload = i_item.reload_limits;
        lane_cmd.track  = track;
        lane_cmd.cal    = r_cal || track;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cac_pkg::T_IDLE: begin
                if (accept) begin
                    n_state = cac_pkg::T_BUSY;
                end
            end
            cac_pkg::T_BUSY: begin
                if (lane_take) begin
                    n_state = cac_pkg::T_IDLE;
                end
            end
            default: n_state = cac_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (r_state == cac_pkg::T_IDLE);
    end

    assign i_item.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cac_pkg::T_IDLE;
            r_cal   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cal   <= n_cal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto    <= 1'b0;
            r_pmin[0] <= cac_pkg::LIMIT_MIN_RST;
            r_pmin[1] <= cac_pkg::LIMIT_MIN_RST;
            r_pmin[2] <= cac_pkg::LIMIT_MIN_RST;
            r_pmax[0] <= cac_pkg::LIMIT_MAX_RST;
            r_pmax[1] <= cac_pkg::LIMIT_MAX_RST;
            r_pmax[2] <= cac_pkg::LIMIT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (cac_pkg::t_cfg_idx'(i_cfg_idx))
                cac_pkg::CFG_AUTO_CAL: r_auto    <= i_cfg_data[0];
                cac_pkg::CFG_MIN_X:    r_pmin[0] <= i_cfg_data;
                cac_pkg::CFG_MIN_Y:    r_pmin[1] <= i_cfg_data;
                cac_pkg::CFG_MIN_Z:    r_pmin[2] <= i_cfg_data;
                cac_pkg::CFG_MAX_X:    r_pmax[0] <= i_cfg_data;
                cac_pkg::CFG_MAX_Y:    r_pmax[1] <= i_cfg_data;
                cac_pkg::CFG_MAX_Z:    r_pmax[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    for (genvar a = 0; a < cac_pkg::AXES; a++) begin : g_lane
        cac_lane #(
            .FRAC_BITS (FRAC_BITS),
            .RAW_WIDTH (RAW_WIDTH)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (lane_cmd),
            .i_raw        (raw[a]),
            .i_preset_min (r_pmin[a]),
            .i_preset_max (r_pmax[a]),
            .i_take       (lane_take),
            .o_res        (lane_res[a])
        );

        assign lane_done[a] = lane_res[a].done;
    end

    cac_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (lane_res),
        .i_err    (r_err),
        .o_take   (lane_take),
        .o_result (o_result)
    );

    `CAC_ASSERT_NOW(a_lanes_in_step, i_clk, i_rst_n, lane_done != '0, &lane_done, "lanes finished out of step")

    `CAC_ASSERT_NOW(a_result_from_item, i_clk, i_rst_n, $rose(o_result.valid), $past(r_state == cac_pkg::T_BUSY), "result appeared with no item in flight")

    `CAC_ASSERT_NEXT(a_lanes_released, i_clk, i_rst_n, lane_take, lane_done == '0, "lanes not released after merge")

endmodule

`default_nettype wire

[verif/compass_axis_calibrator_top_tb.sv]
// ----------------------------------------------------------------------------
// compass_axis_calibrator_top_tb
// Self-checking bench for the magnetometer hard-iron calibrator. A short
// directed plan covers raw pass-through, saturation, measurement errors,
// equal and inverted limits and rounding of halves. Random phases with fresh
// limit settings follow. Each accepted sensor read is run through a local
// model of the limit tracking and scaling, and every result is compared
// field by field in order. Both handshakes idle at random, and one phase
// stalls the output long enough to back the block up.
// ----------------------------------------------------------------------------
module compass_axis_calibrator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 5;
    localparam int FRAC            = cac_pkg::FRAC_BITS_DEF;
    localparam int RANDOM_PHASES   = 13;
    localparam int READS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 3;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int N_DIRECTED      = 29;
    localparam int AX_X            = 0;
    localparam int AX_Y            = 1;
    localparam int AX_Z            = 2;
    localparam int SIDE_SEND       = 0;
    localparam int SIDE_RECV       = 1;

    localparam logic [cac_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum logic {
        ROW_SENSOR,
        ROW_CFG
    } t_plan_kind;

    typedef struct packed {
        logic        reload;
        logic [15:0] x_word;
        logic [15:0] y_word;
        logic [15:0] z_word;
    } t_sensor_read;

    typedef struct packed {
        logic signed [cac_pkg::OUT_W-1:0] fx;
        logic signed [cac_pkg::OUT_W-1:0] fy;
        logic signed [cac_pkg::OUT_W-1:0] fz;
        logic                             err;
        logic                             clip;
    } t_calibrated_field;

    typedef struct packed {
        t_plan_kind                       kind;
        logic [cac_pkg::CFG_IDX_W-1:0]    reg_idx;
        logic [cac_pkg::CFG_W-1:0]        reg_val;
        logic                             reload;
        logic [15:0]                      raw_x;
        logic [15:0]                      raw_y;
        logic [15:0]                      raw_z;
        logic                             typed;
        logic signed [cac_pkg::OUT_W-1:0] fx;
        logic signed [cac_pkg::OUT_W-1:0] fy;
        logic signed [cac_pkg::OUT_W-1:0] fz;
        logic                             err;
        logic                             clip;
    } t_directed_row;

    localparam t_directed_row DIRECTED_PLAN [N_DIRECTED] = '{
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0001, 16'h07FF, 16'hFFFF,
          1'b1, 24'sd4096, 24'sd8384512, -24'sd4096, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0800, 16'h8000, 16'hF801,
          1'b1, cac_pkg::OUT_MAX, cac_pkg::OUT_MIN, -24'sd8384512, 1'b0, 1'b1},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h7FFF, 16'hF800, 16'h0000,
          1'b1, cac_pkg::OUT_MAX, cac_pkg::OUT_MIN, 24'sd0, 1'b0, 1'b1},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'hF000, 16'h1234, 16'h5678,
          1'b1, cac_pkg::OUT_MAX, cac_pkg::OUT_MIN, 24'sd0, 1'b1, 1'b1},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0100, 16'hF000, 16'h0200,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0100, 16'h0200, 16'hF000,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b1, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0190, 16'hFE70, 16'h00C8,
          1'b1, 24'sd4096, -24'sd4096, 24'sd2048, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0001, 16'hFFFF, 16'h7FFF,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MIN_X, 16'hE000, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MAX_X, 16'h2000, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MIN_Y, 16'h0064, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MAX_Y, 16'h0064, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MIN_Z, 16'h012C, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MAX_Z, 16'hFED4, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b1, 16'h0001, 16'h0064, 16'h0000,
          1'b1, 24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b1},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'hFFFF, 16'h0096, 16'hFFFD,
          1'b1, -24'sd1, cac_pkg::OUT_MAX, cac_pkg::OUT_MIN, 1'b0, 1'b1},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h0003, 16'h0032, 16'h0000,
          1'b1, 24'sd2, cac_pkg::OUT_MIN, 24'sd0, 1'b0, 1'b1},
        '{ROW_CFG, cac_pkg::CFG_AUTO_CAL, 16'h0001, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_UNUSED_IDX, 16'hFFFF, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h7FFF, 16'h8000, 16'h1234,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'h8000, 16'h7FFF, 16'hEDCC,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b0, 16'hF000, 16'hF000, 16'hF000,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MIN_X, 16'h8000, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_MAX_X, 16'h7FFF, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_SENSOR, '0, '0, 1'b1, 16'h0000, 16'h0000, 16'h0000,
          1'b0, '0, '0, '0, 1'b0, 1'b0},
        '{ROW_CFG, cac_pkg::CFG_AUTO_CAL, 16'h0000, 1'b0, '0, '0, '0,
          1'b0, '0, '0, '0, 1'b0, 1'b0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [cac_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [cac_pkg::CFG_W-1:0]     i_cfg_data;

    cac_in_if  sensor_ch ();
    cac_out_if field_ch ();

    compass_axis_calibrator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (sensor_ch),
        .o_result   (field_ch)
    );

    logic                              auto_cal_en;
    logic                              is_calibrated;
    logic signed [cac_pkg::CFG_W-1:0]  preset_lo [3];
    logic signed [cac_pkg::CFG_W-1:0]  preset_hi [3];
    logic signed [cac_pkg::CFG_W-1:0]  trk_min [3];
    logic signed [cac_pkg::CFG_W-1:0]  trk_max [3];
    logic signed [cac_pkg::CFG_W-1:0]  held_raw [3];

    t_calibrated_field expected_fields_q [$];

    int  cycle_count      = 0;
    int  mismatches       = 0;
    int  results_checked  = 0;
    int  error_flags_seen = 0;
    int  clipped_seen     = 0;
    int  reads_sent       = 0;
    int  quiet_left [2]   = '{0, 0};
    bit  long_hold_req    = 1'b0;
    bit  eager_sender     = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_fields_q.size());
            $display("compass_axis_calibrator_top verification failed");
            $finish;
        end
    end

    function automatic int draw_gap(input int side);
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left[side] = $urandom_range(8, 48);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] pick_raw_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return cac_pkg::ERR_CODE;
        if (roll < 8) begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (roll < 25)
            return 16'($urandom);
        return 16'($urandom_range(0, 2400)) - 16'd1200;
    endfunction

    function automatic logic [15:0] pick_limit(input bit upper);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return upper ? 16'($urandom_range(50, 1500))
                                  : 16'(-$urandom_range(50, 1500));
        endcase
    endfunction

    function automatic logic signed [cac_pkg::OUT_W-1:0] scale_axis_field(
        input  logic signed [cac_pkg::CFG_W-1:0] raw,
        input  logic signed [cac_pkg::CFG_W-1:0] lo,
        input  logic signed [cac_pkg::CFG_W-1:0] hi,
        inout  logic                             clip
    );
        longint num;
        longint den;
        longint an;
        longint ad;
        longint q;
        if (!is_calibrated) begin
            q = longint'(raw) * (longint'(1) <<< FRAC);
        end else begin
            num = (2 * longint'(raw) - longint'(hi) - longint'(lo)) * (longint'(1) <<< FRAC);
            den = longint'(hi) - longint'(lo);
            if (den == 0) begin
                clip = 1'b1;
                if (num > 0)
                    return cac_pkg::OUT_MAX;
                if (num < 0)
                    return cac_pkg::OUT_MIN;
                return '0;
            end
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q = (2 * an + ad) / (2 * ad);
            if ((num < 0) != (den < 0))
                q = -q;
        end
        if (q > longint'(cac_pkg::OUT_MAX)) begin
            clip = 1'b1;
            return cac_pkg::OUT_MAX;
        end
        if (q < longint'(cac_pkg::OUT_MIN)) begin
            clip = 1'b1;
            return cac_pkg::OUT_MIN;
        end
        return q[cac_pkg::OUT_W-1:0];
    endfunction

    function automatic t_calibrated_field predict_calibration(input t_sensor_read rd);
        logic signed [cac_pkg::CFG_W-1:0] raw [3];
        logic                             bad;
        logic                             clip;
        t_calibrated_field                res;
        raw[AX_X] = rd.x_word;
        raw[AX_Y] = rd.y_word;
        raw[AX_Z] = rd.z_word;
        bad = (raw[AX_X] == cac_pkg::ERR_CODE) || (raw[AX_Y] == cac_pkg::ERR_CODE)
           || (raw[AX_Z] == cac_pkg::ERR_CODE);
        if (!bad)
            for (int a = 0; a < 3; a++)
                held_raw[a] = raw[a];
        if (rd.reload)
            for (int a = 0; a < 3; a++) begin
                trk_min[a] = preset_lo[a];
                trk_max[a] = preset_hi[a];
            end
        if (rd.reload || auto_cal_en) begin
            for (int a = 0; a < 3; a++) begin
                if (held_raw[a] < trk_min[a])
                    trk_min[a] = held_raw[a];
                if (held_raw[a] > trk_max[a])
                    trk_max[a] = held_raw[a];
            end
            is_calibrated = 1'b1;
        end
        clip = 1'b0;
        res.fx = scale_axis_field(held_raw[AX_X], trk_min[AX_X], trk_max[AX_X], clip);
        res.fy = scale_axis_field(held_raw[AX_Y], trk_min[AX_Y], trk_max[AX_Y], clip);
        res.fz = scale_axis_field(held_raw[AX_Z], trk_min[AX_Z], trk_max[AX_Z], clip);
        res.err = bad;
        res.clip = clip;
        return res;
    endfunction

    task automatic write_register(
        input logic [cac_pkg::CFG_IDX_W-1:0] idx,
        input logic [cac_pkg::CFG_W-1:0]     val
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            cac_pkg::CFG_AUTO_CAL: auto_cal_en = val[0];
            cac_pkg::CFG_MIN_X:    preset_lo[AX_X] = val;
            cac_pkg::CFG_MIN_Y:    preset_lo[AX_Y] = val;
            cac_pkg::CFG_MIN_Z:    preset_lo[AX_Z] = val;
            cac_pkg::CFG_MAX_X:    preset_hi[AX_X] = val;
            cac_pkg::CFG_MAX_Y:    preset_hi[AX_Y] = val;
            cac_pkg::CFG_MAX_Z:    preset_hi[AX_Z] = val;
            default:               ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer_read(
        input t_sensor_read      rd,
        input bit                typed,
        input t_calibrated_field want
    );
        int                gap;
        t_calibrated_field model_out;
        gap = eager_sender ? 0 : draw_gap(SIDE_SEND);
        if (gap > 0) begin
            sensor_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sensor_ch.valid         <= 1'b1;
        sensor_ch.reload_limits <= rd.reload;
        sensor_ch.x_high_byte   <= rd.x_word[15:8];
        sensor_ch.x_low_byte    <= rd.x_word[7:0];
        sensor_ch.z_high_byte   <= rd.z_word[15:8];
        sensor_ch.z_low_byte    <= rd.z_word[7:0];
        sensor_ch.y_high_byte   <= rd.y_word[15:8];
        sensor_ch.y_low_byte    <= rd.y_word[7:0];
        do @(posedge i_clk); while (!sensor_ch.ready);
        model_out = predict_calibration(rd);
        expected_fields_q.push_back(typed ? want : model_out);
        reads_sent++;
    endtask

    task automatic wait_drained();
        sensor_ch.valid <= 1'b0;
        while (expected_fields_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(
        input string                     name,
        input logic [cac_pkg::OUT_W-1:0] want,
        input logic [cac_pkg::OUT_W-1:0] got
    );
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_calibrated_field want;
        if (i_rst_n && field_ch.valid && field_ch.ready) begin
            if (expected_fields_q.size() == 0) begin
                $error("Result arrived with no sensor read outstanding");
                mismatches++;
            end else begin
                want = expected_fields_q.pop_front();
                check_field("field_x", want.fx, field_ch.field_x);
                check_field("field_y", want.fy, field_ch.field_y);
                check_field("field_z", want.fz, field_ch.field_z);
                check_field("measure_error", cac_pkg::OUT_W'(want.err),
                            cac_pkg::OUT_W'(field_ch.measure_error));
                check_field("clipped", cac_pkg::OUT_W'(want.clip),
                            cac_pkg::OUT_W'(field_ch.clipped));
                results_checked++;
                if (want.err)
                    error_flags_seen++;
                if (want.clip)
                    clipped_seen++;
            end
        end
    end

    initial begin : result_sink
        int stall;
        field_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                field_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = draw_gap(SIDE_RECV);
            if (stall > 0) begin
                field_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            field_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!field_ch.valid);
        end
    end

    initial begin : stimulus
        t_directed_row     row;
        t_sensor_read      rd;
        t_calibrated_field want;
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= '0;
        i_cfg_data              <= '0;
        sensor_ch.valid         <= 1'b0;
        sensor_ch.reload_limits <= 1'b0;
        sensor_ch.x_high_byte   <= '0;
        sensor_ch.x_low_byte    <= '0;
        sensor_ch.z_high_byte   <= '0;
        sensor_ch.z_low_byte    <= '0;
        sensor_ch.y_high_byte   <= '0;
        sensor_ch.y_low_byte    <= '0;
        auto_cal_en   = 1'b0;
        is_calibrated = 1'b0;
        for (int a = 0; a < 3; a++) begin
            preset_lo[a] = cac_pkg::LIMIT_MIN_RST;
            preset_hi[a] = cac_pkg::LIMIT_MAX_RST;
            trk_min[a]   = cac_pkg::LIMIT_MIN_RST;
            trk_max[a]   = cac_pkg::LIMIT_MAX_RST;
            held_raw[a]  = '0;
        end
        want = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED_PLAN[n];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_register(row.reg_idx, row.reg_val);
            end else begin
                rd = '{row.reload, row.raw_x, row.raw_y, row.raw_z};
                offer_read(rd, row.typed, '{row.fx, row.fy, row.fz, row.err, row.clip});
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            write_register(cac_pkg::CFG_AUTO_CAL, 16'($urandom));
            write_register(cac_pkg::CFG_MIN_X, pick_limit(1'b0));
            write_register(cac_pkg::CFG_MIN_Y, pick_limit(1'b0));
            write_register(cac_pkg::CFG_MIN_Z, pick_limit(1'b0));
            write_register(cac_pkg::CFG_MAX_X, pick_limit(1'b1));
            write_register(cac_pkg::CFG_MAX_Y, pick_limit(1'b1));
            write_register(cac_pkg::CFG_MAX_Z, pick_limit(1'b1));
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_UNUSED_IDX, 16'($urandom));
            if (phase == PRESSURE_PHASE) begin
                long_hold_req = 1'b1;
                eager_sender  = 1'b1;
            end
            for (int k = 0; k < READS_PER_PHASE; k++) begin
                rd.reload = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
                rd.x_word = pick_raw_word();
                rd.y_word = pick_raw_word();
                rd.z_word = pick_raw_word();
                offer_read(rd, 1'b0, want);
            end
            eager_sender = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d sensor reads (%0d directed plan rows).",
                 results_checked, reads_sent, N_DIRECTED);
        $display("Saw %0d measurement errors and %0d clipped results over %0d limit settings.",
                 error_flags_seen, clipped_seen, RANDOM_PHASES + 1);
        if (expected_fields_q.size() != 0) begin
            $error("%0d results never arrived", expected_fields_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("compass_axis_calibrator_top verification clean");
        end else begin
            $display("compass_axis_calibrator_top verification failed");
        end
        $finish;
    end

endmodule
